/* rtl/core/phs_pkg.sv */
// ----------------------------------------------------------------------------
// Pipeline hazard scoreboard package
// Sizes, command and error codes, dependency flag positions and the item
// type that is held in the scoreboard's input stage.
// ----------------------------------------------------------------------------
package phs_pkg;

  localparam int NUM_REGS    = 8;
  localparam int TABLE_DEPTH = 8;

  localparam int REG_W   = 3;
  localparam int ADDR_W  = 16;
  localparam int OFF_W   = 6;
  localparam int FLAGS_W = 6;
  localparam int COUNT_W = 4;
  localparam int ERR_W   = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Dependency flag bit positions.
  localparam int F_SR1 = 0;
  localparam int F_SR2 = 1;
  localparam int F_RM  = 2;
  localparam int F_DR  = 3;
  localparam int F_WM  = 4;
  localparam int F_PC  = 5;

  typedef enum logic [1:0] {
    CMD_CHECK  = 2'd0,
    CMD_ISSUE  = 2'd1,
    CMD_RETIRE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 2'd0,
    ERR_NOT_FOUND = 2'd1,
    ERR_FULL      = 2'd2,
    ERR_COUNT     = 2'd3
  } err_t;

  typedef struct packed {
    cmd_t                     command;
    logic [FLAGS_W-1:0]       dep_flags;
    logic [REG_W-1:0]         src_reg_a;
    logic [REG_W-1:0]         src_reg_b;
    logic [REG_W-1:0]         dst_reg;
    logic                     addr_known;
    logic [ADDR_W-1:0]        mem_addr;
    logic [ADDR_W-1:0]        base_value;
    logic signed [OFF_W-1:0]  offset;
    logic                     word_access;
  } item_t;

endpackage

/* rtl/core/pipeline_hazard_scoreboard.sv */
// ----------------------------------------------------------------------------
// Pipeline hazard scoreboard
// Path: an accepted item is held in the input stage, then in the result
//   register, which it enters when empty or when out_ready takes its result.
// Throughput: one item per cycle while out_ready is high; the scoreboard
//   state is updated as each item leaves the input stage.
// Reset (synchronous, rst_n low) clears all writer counts, the branch flag,
//   the store table and stage valid bits; there is no clearing pass.
// ----------------------------------------------------------------------------
module pipeline_hazard_scoreboard (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_command,
  input  logic [phs_pkg::FLAGS_W-1:0]    in_dep_flags,
  input  logic [phs_pkg::REG_W-1:0]      in_src_reg_a,
  input  logic [phs_pkg::REG_W-1:0]      in_src_reg_b,
  input  logic [phs_pkg::REG_W-1:0]      in_dst_reg,
  input  logic                           in_addr_known,
  input  logic [phs_pkg::ADDR_W-1:0]     in_mem_addr,
  input  logic [phs_pkg::ADDR_W-1:0]     in_base_value,
  input  logic signed [phs_pkg::OFF_W-1:0] in_offset,
  input  logic                           in_word_access,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_stall_res,
  output logic                           out_fetch_blocked,
  output logic [phs_pkg::ADDR_W-1:0]     out_computed_addr,
  output logic                           out_addr_computed,
  output logic [phs_pkg::ERR_W-1:0]      out_error
);
  import phs_pkg::*;

  // Input stage.
  logic  stage_valid_r;
  item_t stage_r;
  logic  advance;

  // Scoreboard state.
  logic [COUNT_W-1:0] writer_count_r   [NUM_REGS];
  logic [COUNT_W-1:0] writer_count_nxt [NUM_REGS];
  logic               branch_pending_r, branch_pending_nxt;
  logic [ADDR_W-1:0]  pend_addr_r      [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] pend_valid_r, pend_valid_nxt;

  // Result register.
  logic               out_valid_r;
  logic               stall_r, fetch_r, computed_r;
  logic [ADDR_W-1:0]  caddr_r;
  err_t               err_r;

  // Combinational results.
  logic               busy_a, busy_b;
  logic [ADDR_W-1:0]  off_ext, off_scaled, caddr, cmp_addr;
  logic [TABLE_DEPTH-1:0] match_oh, free_oh;
  logic               any_match, any_free, taken_m, taken_f;
  logic               stall_nxt, computed_nxt;
  logic [ADDR_W-1:0]  caddr_nxt;
  logic               e_not_found, e_full, e_count;
  err_t               err_nxt;

  assign advance  = stage_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stage_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ready) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r.command     <= cmd_t'(in_command);
      stage_r.dep_flags   <= in_dep_flags;
      stage_r.src_reg_a   <= in_src_reg_a;
      stage_r.src_reg_b   <= in_src_reg_b;
      stage_r.dst_reg     <= in_dst_reg;
      stage_r.addr_known  <= in_addr_known;
      stage_r.mem_addr    <= in_mem_addr;
      stage_r.base_value  <= in_base_value;
      stage_r.offset      <= in_offset;
      stage_r.word_access <= in_word_access;
    end
  end

  // Register busy lookups; a register number past the file is never busy.
  always_comb begin
    busy_a = 1'b0;
    busy_b = 1'b0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (REG_W'(i) == stage_r.src_reg_a && i < (1 << REG_W)) begin
        busy_a = (writer_count_r[i] != '0);
      end
      if (REG_W'(i) == stage_r.src_reg_b && i < (1 << REG_W)) begin
        busy_b = (writer_count_r[i] != '0);
      end
    end
  end

  // Load address: base plus sign-extended offset, doubled for word loads.
  assign off_ext    = {{(ADDR_W-OFF_W){stage_r.offset[OFF_W-1]}}, stage_r.offset};
  assign off_scaled = stage_r.word_access ? {off_ext[ADDR_W-2:0], 1'b0} : off_ext;
  assign caddr      = stage_r.base_value + off_scaled;

  // One shared compare address: the computed load address for a check whose
  // address is not yet known, the supplied address otherwise.
  assign cmp_addr = (stage_r.command == CMD_CHECK && !stage_r.addr_known) ?
                    caddr : stage_r.mem_addr;

  // Lowest matching valid entry and lowest free entry, as one-hot masks.
  always_comb begin
    match_oh = '0;
    free_oh  = '0;
    taken_m  = 1'b0;
    taken_f  = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!taken_m && pend_valid_r[i] &&
          pend_addr_r[i][ADDR_W-1:1] == cmp_addr[ADDR_W-1:1]) begin
        match_oh[i] = 1'b1;
        taken_m     = 1'b1;
      end
      if (!taken_f && !pend_valid_r[i]) begin
        free_oh[i] = 1'b1;
        taken_f    = 1'b1;
      end
    end
  end

  assign any_match = |match_oh;
  assign any_free  = |free_oh;

  always_comb begin
    writer_count_nxt   = writer_count_r;
    branch_pending_nxt = branch_pending_r;
    pend_valid_nxt     = pend_valid_r;
    stall_nxt          = 1'b0;
    computed_nxt       = 1'b0;
    caddr_nxt          = '0;
    e_not_found        = 1'b0;
    e_full             = 1'b0;
    e_count            = 1'b0;

    case (stage_r.command)
      CMD_CHECK: begin
        if (stage_r.dep_flags[F_SR1] && busy_a) stall_nxt = 1'b1;
        if (stage_r.dep_flags[F_SR2] && busy_b) stall_nxt = 1'b1;
        if (stage_r.dep_flags[F_RM]) begin
          if (!stage_r.addr_known && busy_a) begin
            // Base register still pending: no address, no memory compare.
            stall_nxt = 1'b1;
          end else begin
            if (!stage_r.addr_known) begin
              caddr_nxt    = caddr;
              computed_nxt = 1'b1;
            end
            if (any_match) stall_nxt = 1'b1;
          end
        end
      end
      CMD_ISSUE: begin
        if (stage_r.dep_flags[F_PC]) branch_pending_nxt = 1'b1;
        if (stage_r.dep_flags[F_DR]) begin
          for (int i = 0; i < NUM_REGS; i++) begin
            if (REG_W'(i) == stage_r.dst_reg && i < (1 << REG_W)) begin
              if (writer_count_r[i] == COUNT_MAX) begin
                e_count = 1'b1;
              end else begin
                writer_count_nxt[i] = writer_count_r[i] + COUNT_W'(1);
              end
            end
          end
        end
        if (stage_r.dep_flags[F_WM]) begin
          if (!any_free) begin
            e_full = 1'b1;
          end else begin
            pend_valid_nxt = pend_valid_r | free_oh;
          end
        end
      end
      CMD_RETIRE: begin
        if (stage_r.dep_flags[F_PC]) branch_pending_nxt = 1'b0;
        if (stage_r.dep_flags[F_WM]) begin
          if (!any_match) begin
            e_not_found = 1'b1;
          end else begin
            pend_valid_nxt = pend_valid_r & ~match_oh;
          end
        end
        if (stage_r.dep_flags[F_DR]) begin
          for (int i = 0; i < NUM_REGS; i++) begin
            if (REG_W'(i) == stage_r.dst_reg && i < (1 << REG_W)) begin
              if (writer_count_r[i] == '0) begin
                e_count = 1'b1;
              end else begin
                writer_count_nxt[i] = writer_count_r[i] - COUNT_W'(1);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    // The lowest nonzero error code wins.
    if (e_not_found)  err_nxt = ERR_NOT_FOUND;
    else if (e_full)  err_nxt = ERR_FULL;
    else if (e_count) err_nxt = ERR_COUNT;
    else              err_nxt = ERR_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        writer_count_r[i] <= '0;
      end
      branch_pending_r <= 1'b0;
      pend_valid_r     <= '0;
    end else if (advance) begin
      writer_count_r   <= writer_count_nxt;
      branch_pending_r <= branch_pending_nxt;
      pend_valid_r     <= pend_valid_nxt;
    end
  end

  // Store addresses go into the lowest free entry; no reset needed.
  always_ff @(posedge clk) begin
    if (advance && stage_r.command == CMD_ISSUE && stage_r.dep_flags[F_WM]) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (free_oh[i]) pend_addr_r[i] <= stage_r.mem_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stall_r    <= stall_nxt;
      fetch_r    <= branch_pending_nxt;
      caddr_r    <= caddr_nxt;
      computed_r <= computed_nxt;
      err_r      <= err_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_stall_res     = stall_r;
  assign out_fetch_blocked = fetch_r;
  assign out_computed_addr = caddr_r;
  assign out_addr_computed = computed_r;
  assign out_error         = err_r;

  // A check never reports an error.
  a_check_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stage_r.command == CMD_CHECK |-> err_nxt == ERR_NONE)
    else $error("check command produced an error code");

  // Only a check can stall or compute an address.
  a_non_check_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stage_r.command != CMD_CHECK |-> !stall_nxt && !computed_nxt)
    else $error("non-check command reported a stall or an address");

  // A successful store issue occupies exactly one more table entry.
  a_store_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stage_r.command == CMD_ISSUE && stage_r.dep_flags[F_WM] && any_free
    |=> $countones(pend_valid_r) == $past($countones(pend_valid_r)) + 1)
    else $error("store issue did not allocate one table entry");

  // The reported fetch block follows the branch flag after each item.
  a_fetch_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_fetch_blocked == branch_pending_r)
    else $error("fetch_blocked does not match the branch flag");

endmodule

/* dv/phs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hazard scoreboard checker
// Watches both handshakes of the scoreboard, keeps its own copy of the writer
// counts, the branch flag and the store table, predicts the result of every
// accepted item and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module phs_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [1:0]                           in_command,
  input  logic [phs_pkg::FLAGS_W-1:0]          in_dep_flags,
  input  logic [phs_pkg::REG_W-1:0]            in_src_reg_a,
  input  logic [phs_pkg::REG_W-1:0]            in_src_reg_b,
  input  logic [phs_pkg::REG_W-1:0]            in_dst_reg,
  input  logic                                 in_addr_known,
  input  logic [phs_pkg::ADDR_W-1:0]           in_mem_addr,
  input  logic [phs_pkg::ADDR_W-1:0]           in_base_value,
  input  logic signed [phs_pkg::OFF_W-1:0]     in_offset,
  input  logic                                 in_word_access,

  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 out_stall_res,
  input  logic                                 out_fetch_blocked,
  input  logic [phs_pkg::ADDR_W-1:0]           out_computed_addr,
  input  logic                                 out_addr_computed,
  input  logic [phs_pkg::ERR_W-1:0]            out_error,

  output int                                   fail_count,
  output int                                   pending_count,
  output int                                   checked_count
);
  import phs_pkg::*;

  typedef struct packed {
    logic              stall;
    logic              fetch;
    logic [ADDR_W-1:0] addr;
    logic              addr_ok;
    err_t              err;
  } hazard_res_t;

  logic [COUNT_W-1:0] writer_cnt [NUM_REGS];
  logic               branch_flag;
  logic [ADDR_W-1:0]  store_addr [TABLE_DEPTH];
  logic               store_vld  [TABLE_DEPTH];

  hazard_res_t awaited_results[$];
  int          mismatches = 0;
  int          checks = 0;

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 40) begin
      $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  function automatic logic reg_busy(logic [REG_W-1:0] r);
    return (int'(r) < NUM_REGS) && (writer_cnt[r] != '0);
  endfunction

  // Lowest valid store entry whose word address matches, or -1.
  function automatic int find_store(logic [ADDR_W-1:0] a);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (store_vld[i] && (store_addr[i][ADDR_W-1:1] == a[ADDR_W-1:1])) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic err_t lower_err(err_t cur, err_t code);
    if (cur == ERR_NONE || code < cur) begin
      return code;
    end
    return cur;
  endfunction

  // Applies one item to the local scoreboard copy and returns its result.
  function automatic hazard_res_t resolve_hazards(item_t it);
    hazard_res_t       r;
    logic [ADDR_W-1:0] off_ext;
    logic [ADDR_W-1:0] rd_addr;
    logic              have;
    int                slot;
    r = '0;
    r.err = ERR_NONE;
    off_ext = {{(ADDR_W-OFF_W){it.offset[OFF_W-1]}}, it.offset};
    if (it.word_access) begin
      off_ext = off_ext << 1;
    end
    case (it.command)
      CMD_CHECK: begin
        if (it.dep_flags[F_SR1] && reg_busy(it.src_reg_a)) r.stall = 1'b1;
        if (it.dep_flags[F_SR2] && reg_busy(it.src_reg_b)) r.stall = 1'b1;
        if (it.dep_flags[F_RM]) begin
          have = 1'b1;
          rd_addr = it.mem_addr;
          if (!it.addr_known) begin
            // A pending base register blocks both the address and the compare.
            if (reg_busy(it.src_reg_a)) begin
              have = 1'b0;
              r.stall = 1'b1;
            end else begin
              r.addr = it.base_value + off_ext;
              r.addr_ok = 1'b1;
              rd_addr = r.addr;
            end
          end
          if (have && find_store(rd_addr) >= 0) r.stall = 1'b1;
        end
      end
      CMD_ISSUE: begin
        if (it.dep_flags[F_PC]) branch_flag = 1'b1;
        if (it.dep_flags[F_DR] && int'(it.dst_reg) < NUM_REGS) begin
          if (writer_cnt[it.dst_reg] == COUNT_MAX) begin
            r.err = lower_err(r.err, ERR_COUNT);
          end else begin
            writer_cnt[it.dst_reg] = writer_cnt[it.dst_reg] + COUNT_W'(1);
          end
        end
        if (it.dep_flags[F_WM]) begin
          slot = -1;
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!store_vld[i] && slot < 0) slot = i;
          end
          if (slot < 0) begin
            r.err = lower_err(r.err, ERR_FULL);
          end else begin
            store_addr[slot] = it.mem_addr;
            store_vld[slot] = 1'b1;
          end
        end
      end
      CMD_RETIRE: begin
        if (it.dep_flags[F_PC]) branch_flag = 1'b0;
        if (it.dep_flags[F_WM]) begin
          slot = find_store(it.mem_addr);
          if (slot < 0) begin
            r.err = lower_err(r.err, ERR_NOT_FOUND);
          end else begin
            store_vld[slot] = 1'b0;
          end
        end
        if (it.dep_flags[F_DR] && int'(it.dst_reg) < NUM_REGS) begin
          if (writer_cnt[it.dst_reg] == '0) begin
            r.err = lower_err(r.err, ERR_COUNT);
          end else begin
            writer_cnt[it.dst_reg] = writer_cnt[it.dst_reg] - COUNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    r.fetch = branch_flag;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    hazard_res_t want;
    item_t       it;
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) writer_cnt[i] = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) store_vld[i] = 1'b0;
      branch_flag = 1'b0;
      awaited_results.delete();
    end else begin
      // The result leaving now always belongs to an older item, so it is
      // matched before this cycle's item is predicted.
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no item waiting", out_error, 0);
        end else begin
          want = awaited_results.pop_front();
          checks++;
          if (out_stall_res !== want.stall)
            report_mismatch("stall_res", out_stall_res, want.stall);
          if (out_fetch_blocked !== want.fetch)
            report_mismatch("fetch_blocked", out_fetch_blocked, want.fetch);
          if (out_computed_addr !== want.addr)
            report_mismatch("computed_addr", out_computed_addr, want.addr);
          if (out_addr_computed !== want.addr_ok)
            report_mismatch("addr_computed", out_addr_computed, want.addr_ok);
          if (out_error !== want.err)
            report_mismatch("error", out_error, want.err);
        end
      end
      if (in_valid && in_ready) begin
        it.command     = cmd_t'(in_command);
        it.dep_flags   = in_dep_flags;
        it.src_reg_a   = in_src_reg_a;
        it.src_reg_b   = in_src_reg_b;
        it.dst_reg     = in_dst_reg;
        it.addr_known  = in_addr_known;
        it.mem_addr    = in_mem_addr;
        it.base_value  = in_base_value;
        it.offset      = in_offset;
        it.word_access = in_word_access;
        awaited_results.push_back(resolve_hazards(it));
      end
    end
    pending_count <= awaited_results.size();
    fail_count    <= mismatches;
    checked_count <= checks;
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipeline hazard scoreboard testbench
// Drives a directed set of hazard cases and then random check, issue and
// retire traffic in balanced, filling and draining phases, with random idle
// cycles on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import phs_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int POOL_SIZE    = 8;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_command = '0;
  logic [FLAGS_W-1:0]      in_dep_flags = '0;
  logic [REG_W-1:0]        in_src_reg_a = '0;
  logic [REG_W-1:0]        in_src_reg_b = '0;
  logic [REG_W-1:0]        in_dst_reg = '0;
  logic                    in_addr_known = 1'b0;
  logic [ADDR_W-1:0]       in_mem_addr = '0;
  logic [ADDR_W-1:0]       in_base_value = '0;
  logic signed [OFF_W-1:0] in_offset = '0;
  logic                    in_word_access = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_stall_res;
  logic                    out_fetch_blocked;
  logic [ADDR_W-1:0]       out_computed_addr;
  logic                    out_addr_computed;
  logic [ERR_W-1:0]        out_error;

  int fail_count;
  int pending_count;
  int checked_count;

  int          cycles = 0;
  int          items_sent = 0;
  logic        quiet = 1'b0;
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  item_t       in_flight[$];

  pipeline_hazard_scoreboard u_top (.*);

  phs_checker u_check (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending_count);
      $display("FAIL pipeline_hazard_scoreboard");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 15);
    end
  end

  task automatic send(item_t it);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 15) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command     <= it.command;
    in_dep_flags   <= it.dep_flags;
    in_src_reg_a   <= it.src_reg_a;
    in_src_reg_b   <= it.src_reg_b;
    in_dst_reg     <= it.dst_reg;
    in_addr_known  <= it.addr_known;
    in_mem_addr    <= it.mem_addr;
    in_base_value  <= it.base_value;
    in_offset      <= it.offset;
    in_word_access <= it.word_access;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic item_t mk(cmd_t cmd, logic [FLAGS_W-1:0] flags, logic [REG_W-1:0] a,
                               logic [REG_W-1:0] b, logic [REG_W-1:0] d, logic known,
                               logic [ADDR_W-1:0] maddr, logic [ADDR_W-1:0] base,
                               logic signed [OFF_W-1:0] off, logic word);
    item_t it;
    it.command = cmd;
    it.dep_flags = flags;
    it.src_reg_a = a;
    it.src_reg_b = b;
    it.dst_reg = d;
    it.addr_known = known;
    it.mem_addr = maddr;
    it.base_value = base;
    it.offset = off;
    it.word_access = word;
    return it;
  endfunction

  // Mostly a pool word with a random byte bit, so stores and reads collide.
  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 99) < 80) begin
      return addr_pool[$urandom_range(0, POOL_SIZE-1)] ^ ADDR_W'($urandom_range(0, 1));
    end
    return ADDR_W'($urandom);
  endfunction

  // mode 0 is balanced, mode 1 fills the counters and table, mode 2 drains.
  function automatic item_t make_random(int mode);
    item_t              it;
    item_t              old;
    int                 roll;
    int                 k;
    int                 chk_pct;
    int                 iss_pct;
    int                 ret_pct;
    logic signed [ADDR_W-1:0] soff;
    it.dep_flags   = FLAGS_W'($urandom);
    it.src_reg_a   = REG_W'($urandom);
    it.src_reg_b   = REG_W'($urandom);
    it.dst_reg     = REG_W'($urandom);
    it.addr_known  = 1'($urandom_range(0, 1));
    it.mem_addr    = pick_addr();
    it.base_value  = ADDR_W'($urandom);
    it.offset      = OFF_W'($urandom);
    it.word_access = 1'($urandom_range(0, 1));
    case (mode)
      1:       begin chk_pct = 20; iss_pct = 65; ret_pct = 10; end
      2:       begin chk_pct = 20; iss_pct = 10; ret_pct = 65; end
      default: begin chk_pct = 40; iss_pct = 30; ret_pct = 25; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < chk_pct) begin
      it.command = CMD_CHECK;
      if ($urandom_range(0, 1) == 1) begin
        // Aim the computed load address at an address from the store picker.
        soff = ADDR_W'(it.offset);
        if (it.word_access) soff = soff <<< 1;
        it.base_value = pick_addr() - soff;
      end
    end else if (roll < chk_pct + iss_pct) begin
      it.command = CMD_ISSUE;
      if (mode == 1 && $urandom_range(0, 1) == 1) it.dst_reg = REG_W'($urandom_range(0, 1));
      if (in_flight.size() < 64) in_flight.push_back(it);
    end else if (roll < chk_pct + iss_pct + ret_pct) begin
      it.command = CMD_RETIRE;
      if (in_flight.size() > 0 && $urandom_range(0, 99) < 80) begin
        k = $urandom_range(0, in_flight.size() - 1);
        old = in_flight[k];
        in_flight.delete(k);
        it.dep_flags = old.dep_flags;
        it.dst_reg = old.dst_reg;
        it.mem_addr = old.mem_addr ^ ADDR_W'($urandom_range(0, 1));
      end
    end else begin
      it.command = CMD_NONE;
    end
    return it;
  endfunction

  initial begin : stimulus
    int directed;
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = ADDR_W'($urandom);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Empty scoreboard: no stalls, address wrap in both directions.
    send(mk(CMD_CHECK, 6'h00, 3'd0, 3'd0, 3'd0, 1'b0, 16'h0000, 16'h0000, 6'sd0, 1'b0));
    send(mk(CMD_CHECK, 6'h04, 3'd0, 3'd0, 3'd0, 1'b0, 16'h0000, 16'hFFFF, 6'sd31, 1'b0));
    send(mk(CMD_CHECK, 6'h04, 3'd0, 3'd0, 3'd0, 1'b0, 16'h0000, 16'h0000, -6'sd32, 1'b1));
    send(mk(CMD_CHECK, 6'h04, 3'd0, 3'd0, 3'd0, 1'b1, 16'hFFFF, 16'h1234, 6'sd5, 1'b1));
    // Retire underflow, retire of a missing store, and both at once.
    send(mk(CMD_RETIRE, 6'h08, 3'd0, 3'd0, 3'd0, 1'b0, 16'h0000, 16'h0000, 6'sd0, 1'b0));
    send(mk(CMD_RETIRE, 6'h10, 3'd0, 3'd0, 3'd0, 1'b0, 16'h4000, 16'h0000, 6'sd0, 1'b0));
    send(mk(CMD_RETIRE, 6'h18, 3'd0, 3'd0, 3'd5, 1'b0, 16'h4000, 16'h0000, 6'sd0, 1'b0));
    // Pending writer on r3 with a branch in flight.
    send(mk(CMD_ISSUE, 6'h28, 3'd0, 3'd0, 3'd3, 1'b0, 16'h0000, 16'h0000, 6'sd0, 1'b0));
    send(mk(CMD_CHECK, 6'h01, 3'd3, 3'd0, 3'd0, 1'b0, 16'h0000, 16'h0000, 6'sd0, 1'b0));
    send(mk(CMD_CHECK, 6'h02, 3'd0, 3'd3, 3'd0, 1'b0, 16'h0000, 16'h0000, 6'sd0, 1'b0));
    send(mk(CMD_CHECK, 6'h04, 3'd3, 3'd0, 3'd0, 1'b0, 16'h0000, 16'h1000, 6'sd4, 1'b0));
    send(mk(CMD_CHECK, 6'h06, 3'd0, 3'd3, 3'd0, 1'b0, 16'h0000, 16'h1000, 6'sd4, 1'b1));
    // A pending store is hit by word address, known or computed.
    send(mk(CMD_ISSUE, 6'h10, 3'd0, 3'd0, 3'd0, 1'b0, 16'h1234, 16'h0000, 6'sd0, 1'b0));
    send(mk(CMD_CHECK, 6'h04, 3'd0, 3'd0, 3'd0, 1'b1, 16'h1235, 16'h0000, 6'sd0, 1'b0));
    send(mk(CMD_CHECK, 6'h04, 3'd0, 3'd0, 3'd0, 1'b0, 16'h0000, 16'h1230, 6'sd2, 1'b1));
    send(mk(CMD_RETIRE, 6'h10, 3'd0, 3'd0, 3'd0, 1'b0, 16'h1235, 16'h0000, 6'sd0, 1'b0));
    send(mk(CMD_RETIRE, 6'h28, 3'd0, 3'd0, 3'd3, 1'b0, 16'h0000, 16'h0000, 6'sd0, 1'b0));
    // Unused command, then all flags with top field values (retire 0xFFFE).
    send(mk(CMD_NONE, 6'h3F, 3'd7, 3'd7, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF, 6'sd31, 1'b1));
    send(mk(CMD_ISSUE, 6'h3F, 3'd7, 3'd7, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF, 6'sd31, 1'b1));
    send(mk(CMD_CHECK, 6'h3F, 3'd7, 3'd7, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF, 6'sd31, 1'b1));
    send(mk(CMD_NONE, 6'h3F, 3'd7, 3'd7, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF, 6'sd31, 1'b1));
    send(mk(CMD_RETIRE, 6'h3F, 3'd7, 3'd7, 3'd7, 1'b1, 16'hFFFE, 16'hFFFF, 6'sd31, 1'b1));
    directed = items_sent;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 1000 && n < 1400);
      send(make_random((n / 250) % 4 == 1 ? 1 : ((n / 250) % 4 == 3 ? 2 : 0)));
    end
    quiet = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d items (%0d directed, rest random in balanced, fill and drain phases).",
             items_sent, directed);
    $display("Checked %0d results with random idle cycles on both channels.", checked_count);
    if (fail_count == 0) begin
      $display("PASS pipeline_hazard_scoreboard");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL pipeline_hazard_scoreboard");
    end
    $finish;
  end

endmodule
